@@ design/wdgc_pkg.sv @@
// wdgc_pkg: widths, sideband structs and saturation helpers for the
// wave field synthesis delay and gain unit. No dependencies.
package wdgc_pkg;

  localparam int POS_W   = 24;
  localparam int NRM_W   = 16;
  localparam int DIFF_W  = 25;
  localparam int SQ_W    = 50;
  localparam int LEN_W   = 25;
  localparam int DOT_W   = 42;
  localparam int DOTM_W  = 41;
  localparam int PRD_W   = 33;
  localparam int D_W     = 26;
  localparam int S_W     = 27;
  localparam int DEN_W   = 52;
  localparam int CM_W    = 18;
  localparam int RT_IN_W = 62;
  localparam int Y_W     = 31;
  localparam int DELAY_W = 25;
  localparam int GAIN_W  = 24;

  localparam logic [DELAY_W-1:0] DELAY_MAX = 25'h0FF_FFFF;
  localparam logic [DELAY_W-1:0] DELAY_MIN = 25'h100_0000;
  localparam logic [GAIN_W-1:0]  GAIN_MAX  = 24'h7F_FFFF;
  localparam logic [GAIN_W-1:0]  GAIN_MIN  = 24'h80_0000;

  localparam logic [1:0] ADDR_REF_DIST = 2'd0;

  typedef struct packed {
    logic              plane;
    logic [DOT_W-1:0]  dot;
    logic [PRD_W-1:0]  p;
  } sq_side_t;

  typedef struct packed {
    logic              plane;
    logic              dneg;
    logic [PRD_W-1:0]  p;
    logic [LEN_W-1:0]  len;
    logic [D_W-1:0]    d;
  } cos_side_t;

  typedef struct packed {
    logic               plane;
    logic               kill;
    logic               err;
    logic               dneg;
    logic [CM_W-1:0]    cm;
    logic [DELAY_W-1:0] delay;
    logic [GAIN_W-1:0]  gain_pl;
  } quo_side_t;

  typedef struct packed {
    quo_side_t b;
    logic      sat;
  } rt_side_t;

  // sign and magnitude to saturated two's complement
  function automatic logic [DELAY_W-1:0] clamp_delay(input logic neg, input logic [31:0] m);
    logic [DELAY_W-1:0] r;
    if (neg) begin
      r = (m > 32'h0100_0000) ? DELAY_MIN : DELAY_W'(32'd0 - m);
    end else begin
      r = (m > 32'(DELAY_MAX)) ? DELAY_MAX : DELAY_W'(m);
    end
    return r;
  endfunction

  function automatic logic [GAIN_W-1:0] clamp_gain(input logic neg, input logic [31:0] m);
    logic [GAIN_W-1:0] r;
    if (neg) begin
      r = (m > 32'h0080_0000) ? GAIN_MIN : GAIN_W'(32'd0 - m);
    end else begin
      r = (m > 32'(GAIN_MAX)) ? GAIN_MAX : GAIN_W'(m);
    end
    return r;
  endfunction

endpackage

@@ design/wdgc_isqrt.sv @@
// wdgc_isqrt: pipelined integer square root, one result bit per stage,
// floor result. Carries a sideband vector alongside. No dependencies.
module wdgc_isqrt #(
  parameter int IN_W   = 50,
  parameter int SIDE_W = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [IN_W-1:0]     rad_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic [IN_W/2-1:0]   root_o,
  output logic [SIDE_W-1:0]   side_o
);

  localparam int RT_W  = IN_W / 2;
  localparam int REM_W = RT_W + 2;

  logic              v_q    [RT_W];
  logic [REM_W-1:0]  rem_q  [RT_W];
  logic [RT_W-1:0]   root_q [RT_W];
  logic [IN_W-1:0]   x_q    [RT_W];
  logic [SIDE_W-1:0] side_q [RT_W];

  for (genvar k = 0; k < RT_W; k++) begin : g_stage
    logic              v_p;
    logic [REM_W-1:0]  rem_p;
    logic [RT_W-1:0]   root_p;
    logic [IN_W-1:0]   x_p;
    logic [SIDE_W-1:0] side_p;
    logic [REM_W-1:0]  rem_t;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_p    = valid_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign x_p    = rad_i;
      assign side_p = side_i;
    end else begin : g_next
      assign v_p    = v_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign x_p    = x_q[k-1];
      assign side_p = side_q[k-1];
    end

    // bring down two radicand bits, try root*4+1
    assign rem_t = {rem_p[REM_W-3:0], x_p[IN_W-1 -: 2]};
    assign trial = {root_p, 2'b01};
    assign ge    = (rem_t >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (rem_t - trial) : rem_t;
        root_q[k] <= {root_p[RT_W-2:0], ge};
        x_q[k]    <= x_p << 2;
        side_q[k] <= side_p;
      end
    end
  end

  assign valid_o = v_q[RT_W-1];
  assign root_o  = root_q[RT_W-1];
  assign side_o  = side_q[RT_W-1];

endmodule

@@ design/wdgc_div.sv @@
// wdgc_div: pipelined restoring divider, one quotient bit per stage.
// The numerator must be below den * 2^QUO_W. No dependencies.
module wdgc_div #(
  parameter int NUM_W  = 41,
  parameter int DEN_W  = 25,
  parameter int QUO_W  = 18,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [QUO_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int ACC_W = DEN_W + QUO_W;

  logic              v_q    [QUO_W];
  logic [ACC_W-1:0]  acc_q  [QUO_W];
  logic [DEN_W-1:0]  den_q  [QUO_W];
  logic [SIDE_W-1:0] side_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic              v_p;
    logic [ACC_W-1:0]  acc_p;
    logic [DEN_W-1:0]  den_p;
    logic [SIDE_W-1:0] side_p;
    logic [DEN_W:0]    t;
    logic [DEN_W:0]    nt;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_p    = valid_i;
      assign acc_p  = ACC_W'(num_i);
      assign den_p  = den_i;
      assign side_p = side_i;
    end else begin : g_next
      assign v_p    = v_q[k-1];
      assign acc_p  = acc_q[k-1];
      assign den_p  = den_q[k-1];
      assign side_p = side_q[k-1];
    end

    // partial remainder with the next numerator bit shifted in
    assign t  = acc_p[ACC_W-1:QUO_W-1];
    assign ge = (t >= {1'b0, den_p});
    assign nt = ge ? (t - {1'b0, den_p}) : t;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[k]  <= {nt[DEN_W-1:0], acc_p[QUO_W-2:0], ge};
        den_q[k]  <= den_p;
        side_q[k] <= side_p;
      end
    end
  end

  assign valid_o = v_q[QUO_W-1];
  assign quo_o   = acc_q[QUO_W-1][QUO_W-1:0];
  assign side_o  = side_q[QUO_W-1];

endmodule

@@ design/wfs_delay_gain_coefficient.sv @@
// wfs_delay_gain_coefficient: top level, delay path length and amplitude
// factor per speaker and source. Uses wdgc_pkg, wdgc_isqrt and wdgc_div.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | input     | in_valid_i / in_stall_o | req_type, speaker, source
//  out     | output    | out_valid_o / out_stall_i | delay_distance, gain_factor,
//          |           |                        | math_error
//  cfg     | input     | apb psel/penable/pready | reference_distance
//
// one beat enters per cycle while in_stall_o is low; the pipe includes the
// distance root (25 stages), the cosine divider (18), the radicand divider
// (24 + 3F) and the gain root (31)
// all pipeline stages advance together; out_stall_i with a full output
// register freezes the whole pipe and raises in_stall_o
// reset clears valid bits and loads reference_distance with 1.0
module wfs_delay_gain_coefficient #(
  parameter int POSITION_FRAC_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [wdgc_pkg::POS_W-1:0] speaker_x_i,
  input  logic [wdgc_pkg::POS_W-1:0] speaker_y_i,
  input  logic [wdgc_pkg::NRM_W-1:0] speaker_nx_i,
  input  logic [wdgc_pkg::NRM_W-1:0] speaker_ny_i,
  input  logic [wdgc_pkg::POS_W-1:0] source_x_i,
  input  logic [wdgc_pkg::POS_W-1:0] source_y_i,
  input  logic [wdgc_pkg::NRM_W-1:0] source_nx_i,
  input  logic [wdgc_pkg::NRM_W-1:0] source_ny_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [wdgc_pkg::DELAY_W-1:0] delay_distance_o,
  output logic [wdgc_pkg::GAIN_W-1:0]  gain_factor_o,
  output logic        math_error_o
);
  import wdgc_pkg::*;

  localparam int F      = POSITION_FRAC_BITS;
  localparam int HUND   = ((2 ** F) + 50) / 100;
  localparam int NUM_W  = POS_W + 3 * F;
  localparam int QX_W   = (NUM_W > 63) ? NUM_W : 63;
  localparam int GSH    = 28 - F;

  logic en;

  // ---------------- configuration ----------------
  logic signed [POS_W-1:0] r_q;
  logic signed [S_W-1:0]   r27;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= POS_W'(1 << F);
    end else if (psel && penable && pwrite && pready) begin
      r_q <= pwdata[POS_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_REF_DIST) ? {{(32-POS_W){r_q[POS_W-1]}}, r_q} : 32'd0;
  assign r27    = S_W'(r_q);

  // ---------------- stage a: differences ----------------
  logic                     a_v_q, a_plane_q;
  logic signed [DIFF_W-1:0] a_dx_q, a_dy_q;
  logic signed [NRM_W-1:0]  a_nx_q, a_ny_q, a_snx_q, a_sny_q;
  logic signed [DIFF_W-1:0] a_dx_d, a_dy_d;

  assign a_dx_d = $signed({speaker_x_i[POS_W-1], speaker_x_i})
                - $signed({source_x_i[POS_W-1], source_x_i});
  assign a_dy_d = $signed({speaker_y_i[POS_W-1], speaker_y_i})
                - $signed({source_y_i[POS_W-1], source_y_i});

  // ---------------- stage b: products ----------------
  logic                   b_v_q, b_plane_q;
  logic [SQ_W-1:0]        b_xx_q, b_yy_q;
  logic signed [40:0]     b_xn_q, b_yn_q;
  logic signed [31:0]     b_pxx_q, b_pyy_q;
  logic signed [SQ_W-1:0] xx_d, yy_d;
  logic signed [40:0]     xn_d, yn_d;
  logic signed [31:0]     pxx_d, pyy_d;

  always_comb begin
    xx_d  = SQ_W'(a_dx_q * a_dx_q);
    yy_d  = SQ_W'(a_dy_q * a_dy_q);
    xn_d  = 41'(a_dx_q * a_nx_q);
    yn_d  = 41'(a_dy_q * a_ny_q);
    pxx_d = 32'(a_snx_q * a_nx_q);
    pyy_d = 32'(a_sny_q * a_ny_q);
  end

  // ---------------- stage c: sums ----------------
  logic                    c_v_q;
  logic [SQ_W-1:0]         c_sum_q;
  sq_side_t                c_side_q;
  logic signed [DOT_W-1:0] dot_d;
  logic signed [PRD_W-1:0] p_d;

  always_comb begin
    dot_d = DOT_W'(b_xn_q + b_yn_q);
    p_d   = PRD_W'(b_pxx_q + b_pyy_q);
  end

  // ---------------- distance root ----------------
  logic             s1_v;
  logic [LEN_W-1:0] s1_len;
  sq_side_t         s1_side;

  wdgc_isqrt #(.IN_W(SQ_W), .SIDE_W($bits(sq_side_t))) u_len_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c_v_q),
    .rad_i   (c_sum_q),
    .side_i  (c_side_q),
    .valid_o (s1_v),
    .root_o  (s1_len),
    .side_o  (s1_side)
  );

  // ---------------- stage d: delay, dot magnitude ----------------
  logic              d_v_q;
  logic [DOTM_W-1:0] d_num_q;
  logic [LEN_W-1:0]  d_den_q;
  cos_side_t         d_side_q;
  cos_side_t         d_side_d;
  logic signed [S_W-1:0] len27;
  logic [DOT_W-1:0]  dot_neg;

  always_comb begin
    len27          = $signed({2'b00, s1_len});
    dot_neg        = DOT_W'(0) - s1_side.dot;
    d_side_d.plane = s1_side.plane;
    d_side_d.dneg  = s1_side.dot[DOT_W-1];
    d_side_d.p     = s1_side.p;
    d_side_d.len   = s1_len;
    // nudge the delay off the pole where length equals minus the reference
    d_side_d.d     = (len27 == -r27) ? (D_W'(s1_len) + D_W'(HUND)) : D_W'(s1_len);
  end

  // ---------------- cosine divider ----------------
  logic            cq_v;
  logic [CM_W-1:0] cq_cm;
  cos_side_t       cq_side;

  wdgc_div #(.NUM_W(DOTM_W), .DEN_W(LEN_W), .QUO_W(CM_W), .SIDE_W($bits(cos_side_t)))
  u_cos_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_v_q),
    .num_i   (d_num_q),
    .den_i   (d_den_q),
    .side_i  (d_side_q),
    .valid_o (cq_v),
    .quo_o   (cq_cm),
    .side_o  (cq_side)
  );

  // ---------------- stage e: radicand sign, plane partials ----------------
  logic                e_v_q, e_plane_q, e_err_q, e_kill_q, e_dneg_q;
  logic [CM_W-1:0]     e_cm_q;
  logic [D_W-1:0]      e_d_q, e_smag_q;
  logic [PRD_W-1:0]    e_p_q;
  logic [40:0]         e_plo_q;
  logic signed [42:0]  e_phi_q;
  logic signed [S_W-1:0] s_d;
  logic                err_d, kill_d, r_pos, r_neg, s_pos, s_neg;
  logic [40:0]         plo_d;
  logic signed [42:0]  phi_d;

  always_comb begin
    s_d    = $signed({1'b0, cq_side.d}) + r27;
    r_neg  = r_q[POS_W-1];
    r_pos  = !r_q[POS_W-1] && (r_q != '0);
    s_neg  = s_d[S_W-1];
    s_pos  = !s_d[S_W-1] && (s_d != '0);
    err_d  = !cq_side.plane && ((cq_side.len == '0) || (s_d == '0) ||
             (r_pos && s_neg) || (r_neg && s_pos));
    kill_d = err_d || (r_q == '0) || (cq_cm == '0);
    plo_d  = 41'(cq_side.len) * 41'(cq_side.p[15:0]);
    phi_d  = 43'($signed({1'b0, cq_side.len}) * $signed(cq_side.p[PRD_W-1:16]));
  end

  // ---------------- stage f: denominator, plane delay product ----------------
  logic                f_v_q, f_plane_q, f_err_q, f_kill_q, f_dneg_q;
  logic [CM_W-1:0]     f_cm_q;
  logic [D_W-1:0]      f_d_q;
  logic [PRD_W-1:0]    f_p_q;
  logic [DEN_W-1:0]    f_den_q;
  logic signed [57:0]  f_lp_q;
  logic signed [57:0]  phx, lp_d;

  always_comb begin
    phx  = 58'(e_phi_q);
    lp_d = (phx <<< 16) + $signed({17'b0, e_plo_q});
  end

  // ---------------- stage g: rounding, numerator ----------------
  logic             g_v_q;
  logic [NUM_W-1:0] g_num_q;
  logic [DEN_W-1:0] g_den_q;
  quo_side_t        g_side_q;
  quo_side_t        g_side_d;
  logic [57:0]      lpm, lpr;
  logic [PRD_W-1:0] pm;
  logic [PRD_W:0]   pr;
  logic [POS_W-1:0] rmag;
  logic [DELAY_W-1:0] dl_pl, dl_pt;

  always_comb begin
    lpm   = f_lp_q[57] ? (58'd0 - 58'(f_lp_q)) : 58'(f_lp_q);
    lpr   = (lpm + (58'd1 << 27)) >> 28;
    dl_pl = clamp_delay(f_lp_q[57], 32'(lpr));
    dl_pt = clamp_delay(1'b0, 32'(f_d_q));
    pm    = f_p_q[PRD_W-1] ? (PRD_W'(0) - f_p_q) : f_p_q;
    pr    = ({1'b0, pm} + ((PRD_W+1)'(1) << (GSH - 1))) >> GSH;
    rmag  = r_q[POS_W-1] ? (POS_W'(0) - r_q) : r_q;

    g_side_d.plane   = f_plane_q;
    g_side_d.kill    = f_kill_q;
    g_side_d.err     = f_err_q;
    g_side_d.dneg    = f_dneg_q;
    g_side_d.cm      = f_cm_q;
    g_side_d.delay   = f_plane_q ? dl_pl : dl_pt;
    g_side_d.gain_pl = clamp_gain(f_p_q[PRD_W-1], 32'(pr));
  end

  // ---------------- radicand divider ----------------
  logic             bq_v;
  logic [NUM_W-1:0] bq_q;
  quo_side_t        bq_side;
  logic [QX_W-1:0]  q_ext;
  rt_side_t         rt_side_d;

  wdgc_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(NUM_W), .SIDE_W($bits(quo_side_t)))
  u_rad_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (g_v_q),
    .num_i   (g_num_q),
    .den_i   (g_den_q),
    .side_i  (g_side_q),
    .valid_o (bq_v),
    .quo_o   (bq_q),
    .side_o  (bq_side)
  );

  // quotient at or above 2^62 saturates the gain
  always_comb begin
    q_ext         = QX_W'(bq_q);
    rt_side_d.b   = bq_side;
    rt_side_d.sat = |q_ext[QX_W-1:RT_IN_W];
  end

  // ---------------- gain root ----------------
  logic           s2_v;
  logic [Y_W-1:0] s2_y;
  rt_side_t       s2_side;

  wdgc_isqrt #(.IN_W(RT_IN_W), .SIDE_W($bits(rt_side_t))) u_gain_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (bq_v),
    .rad_i   (q_ext[RT_IN_W-1:0]),
    .side_i  (rt_side_d),
    .valid_o (s2_v),
    .root_o  (s2_y),
    .side_o  (s2_side)
  );

  // ---------------- stage i: cosine times root ----------------
  logic         i_v_q;
  logic [48:0]  i_m_q;
  rt_side_t     i_side_q;

  // ---------------- output stage ----------------
  logic               o_v_q;
  logic [DELAY_W-1:0] o_delay_q;
  logic [GAIN_W-1:0]  o_gain_q;
  logic               o_err_q;
  logic [GAIN_W-1:0]  o_gain_d;
  logic [34:0]        mr;
  logic [31:0]        mg;

  always_comb begin
    mr = 35'((i_m_q + 49'd8192) >> 14);
    if (i_side_q.sat || (mr > 35'h80_0000)) begin
      mg = 32'h0080_0000;
    end else begin
      mg = 32'(mr);
    end
    if (i_side_q.b.plane) begin
      o_gain_d = i_side_q.b.gain_pl;
    end else if (i_side_q.b.kill) begin
      o_gain_d = '0;
    end else begin
      o_gain_d = clamp_gain(i_side_q.b.dneg, mg);
    end
  end

  assign en = !o_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
      g_v_q <= 1'b0;
      i_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= in_valid_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= s1_v;
      e_v_q <= cq_v;
      f_v_q <= e_v_q;
      g_v_q <= f_v_q;
      i_v_q <= s2_v;
      o_v_q <= i_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_plane_q <= req_type_i;
      a_dx_q    <= a_dx_d;
      a_dy_q    <= a_dy_d;
      a_nx_q    <= speaker_nx_i;
      a_ny_q    <= speaker_ny_i;
      a_snx_q   <= source_nx_i;
      a_sny_q   <= source_ny_i;

      b_plane_q <= a_plane_q;
      b_xx_q    <= xx_d;
      b_yy_q    <= yy_d;
      b_xn_q    <= xn_d;
      b_yn_q    <= yn_d;
      b_pxx_q   <= pxx_d;
      b_pyy_q   <= pyy_d;

      c_sum_q        <= b_xx_q + b_yy_q;
      c_side_q.plane <= b_plane_q;
      c_side_q.dot   <= dot_d;
      c_side_q.p     <= p_d;

      d_num_q  <= s1_side.dot[DOT_W-1] ? dot_neg[DOTM_W-1:0] : s1_side.dot[DOTM_W-1:0];
      d_den_q  <= (s1_len == '0) ? LEN_W'(1) : s1_len;
      d_side_q <= d_side_d;

      e_plane_q <= cq_side.plane;
      e_err_q   <= err_d;
      e_kill_q  <= kill_d;
      e_dneg_q  <= cq_side.dneg;
      e_cm_q    <= cq_cm;
      e_d_q     <= cq_side.d;
      e_smag_q  <= s_d[S_W-1] ? D_W'(-s_d) : D_W'(s_d);
      e_p_q     <= cq_side.p;
      e_plo_q   <= plo_d;
      e_phi_q   <= phi_d;

      f_plane_q <= e_plane_q;
      f_err_q   <= e_err_q;
      f_kill_q  <= e_kill_q;
      f_dneg_q  <= e_dneg_q;
      f_cm_q    <= e_cm_q;
      f_d_q     <= e_d_q;
      f_p_q     <= e_p_q;
      f_den_q   <= DEN_W'(e_smag_q * e_d_q);
      f_lp_q    <= lp_d;

      g_num_q  <= NUM_W'(rmag) << (3 * F);
      g_den_q  <= f_den_q;
      g_side_q <= g_side_d;

      i_m_q    <= 49'(s2_side.b.cm * s2_y);
      i_side_q <= s2_side;

      o_delay_q <= i_side_q.b.delay;
      o_gain_q  <= o_gain_d;
      o_err_q   <= i_side_q.b.err;
    end
  end

  assign in_stall_o       = !en;
  assign out_valid_o      = o_v_q;
  assign delay_distance_o = o_delay_q;
  assign gain_factor_o    = o_gain_q;
  assign math_error_o     = o_err_q;

endmodule
